// ===== src/u8sc_pkg.sv =====
// u8sc_pkg: shared types, codes and constants for the UTF-8 structure checker.
// Used by u8sc_classify, u8sc_core and utf8_structure_checker_top.
package u8sc_pkg;

    localparam int OFFSET_BITS_DEF = 32;   // default width of the internal offset
    localparam int ERR_OFFSET_W    = 32;   // width of the reported error offset

    // Masks for the continuation byte test (10xxxxxx)
    localparam logic [7:0] PAYLOAD_MASK = 8'b0011_1111;
    localparam logic [7:0] CONT_MARK    = 8'b1000_0000;

    // Request opcodes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_VALID   = 2'd1,
        VERDICT_INVALID = 2'd2
    } t_verdict;

    // Decode of one stream byte
    typedef struct packed {
        logic       lead_ok;    // legal lead byte (ASCII or multi-byte start)
        logic [1:0] lead_len;   // continuation bytes the lead requires
        logic       is_cont;    // byte is 10xxxxxx
    } t_byte_class;

    // One result item
    typedef struct packed {
        t_verdict                  verdict;
        logic [ERR_OFFSET_W-1:0]   error_offset;
    } t_result;

endpackage

// ===== src/utf8_structure_checker_top.sv =====
// A request is taken into the input register; its result is then loaded from the core
// into the result register once that register is empty or being drained.
// Throughput: one request per cycle while the result side keeps draining, set by the
// combinational classify and the registered state update in u8sc_core.
// A waiting result blocks intake only once the input register is full: the input
// register takes requests while it is empty or while the result register can load.
// Reset (i_rst_n low, synchronous): both stages empty, all tracking state zero.
//
// utf8_structure_checker_top: valid/ready wrapper around u8sc_core.
// Depends on u8sc_pkg, u8sc_core, u8sc_classify.
module utf8_structure_checker_top #(
    parameter int OFFSET_BITS = u8sc_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [7:0]                        i_data_byte,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_verdict,
    output logic [u8sc_pkg::ERR_OFFSET_W-1:0] o_error_offset
);

    // Input register: holds one request for the core
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    // Result register
    logic              r_out_valid;
    u8sc_pkg::t_result r_result;

    u8sc_pkg::t_result w_result;
    logic              w_out_free;   // result register can load this cycle
    logic              w_step;       // core consumes the held request

    // The result register loads when it is empty or being drained this cycle.
    assign w_out_free = !r_out_valid || i_ready;
    assign w_step     = r_in_valid && w_out_free;
    // The input register takes a new request when it is empty or advancing.
    assign o_ready    = !r_in_valid || w_out_free;

    u8sc_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_op        (r_in_op),
        .i_data_byte (r_in_byte),
        .o_result    (w_result)
    );

    // Valid flags: control state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_step;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op   <= i_op;
            r_in_byte <= i_data_byte;
        end
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_verdict      = r_result.verdict;
    assign o_error_offset = r_result.error_offset;

endmodule

// ===== src/u8sc_classify.sv =====
// u8sc_classify: combinational decode of one byte into lead length and
// continuation flag. Depends on u8sc_pkg.
module u8sc_classify (
    input  logic [7:0]            i_data_byte,
    output u8sc_pkg::t_byte_class o_class
);

    always_comb begin
        o_class.is_cont  = (i_data_byte & ~u8sc_pkg::PAYLOAD_MASK) == u8sc_pkg::CONT_MARK;
        o_class.lead_ok  = 1'b1;
        o_class.lead_len = 2'd0;
        priority if (i_data_byte[7] == 1'b0) begin
            o_class.lead_len = 2'd0;
        end else if (i_data_byte[7:5] == 3'b110) begin
            o_class.lead_len = 2'd1;
        end else if (i_data_byte[7:4] == 4'b1110) begin
            o_class.lead_len = 2'd2;
        end else if (i_data_byte[7:3] == 5'b11110) begin
            o_class.lead_len = 2'd3;
        end else begin
            o_class.lead_ok  = 1'b0;
        end
    end

endmodule

// ===== src/u8sc_core.sv =====
// u8sc_core: sequence tracking state, offset counter and verdict logic.
// Depends on u8sc_pkg and u8sc_classify.
module u8sc_core #(
    parameter int OFFSET_BITS = u8sc_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,        // consume one request this cycle
    input  logic              i_op,
    input  logic [7:0]        i_data_byte,
    output u8sc_pkg::t_result o_result       // result of the request being consumed
);

    u8sc_pkg::t_byte_class w_class;

    logic [1:0]             r_expected, n_expected;
    logic [2:0]             r_seq_len,  n_seq_len;
    logic [OFFSET_BITS-1:0] r_start,    n_start;
    logic                   r_error,    n_error;

    logic [2:0]             w_adv_amt;
    logic                   w_adv;
    logic [OFFSET_BITS:0]   w_sum;
    logic [OFFSET_BITS-1:0] w_start_sat;
    logic [OFFSET_BITS+u8sc_pkg::ERR_OFFSET_W-1:0] w_start_wide;

    u8sc_classify u_classify (
        .i_data_byte (i_data_byte),
        .o_class     (w_class)
    );

    // Saturating advance of the sequence start
    assign w_sum       = {1'b0, r_start} + {{(OFFSET_BITS-2){1'b0}}, w_adv_amt};
    assign w_start_sat = w_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : w_sum[OFFSET_BITS-1:0];

    assign w_start_wide = {{u8sc_pkg::ERR_OFFSET_W{1'b0}}, r_start};

    always_comb begin
        n_expected = r_expected;
        n_seq_len  = r_seq_len;
        n_start    = r_start;
        n_error    = r_error;
        w_adv      = 1'b0;
        w_adv_amt  = 3'd1;
        o_result.verdict      = u8sc_pkg::VERDICT_NONE;
        o_result.error_offset = '0;

        if (i_op == u8sc_pkg::OP_END) begin
            if (r_error || (r_expected != 2'd0)) begin
                o_result.verdict      = u8sc_pkg::VERDICT_INVALID;
                o_result.error_offset = w_start_wide[u8sc_pkg::ERR_OFFSET_W-1:0];
            end else begin
                o_result.verdict      = u8sc_pkg::VERDICT_VALID;
            end
            n_expected = 2'd0;
            n_seq_len  = 3'd0;
            n_start    = '0;
            n_error    = 1'b0;
        end else begin
            if (!r_error) begin
                if (r_expected == 2'd0) begin
                    if (!w_class.lead_ok) begin
                        n_error = 1'b1;
                    end else if (w_class.lead_len == 2'd0) begin
                        w_adv = 1'b1;
                    end else begin
                        n_expected = w_class.lead_len;
                        n_seq_len  = {1'b0, w_class.lead_len} + 3'd1;
                    end
                end else if (w_class.is_cont) begin
                    n_expected = r_expected - 2'd1;
                    if (r_expected == 2'd1) begin
                        w_adv     = 1'b1;
                        w_adv_amt = r_seq_len;
                        n_seq_len = 3'd0;
                    end
                end else begin
                    n_error = 1'b1;
                end
            end
            if (w_adv) begin
                n_start = w_start_sat;
            end
            // Start never moves on the cycle an error is found
            if (n_error) begin
                o_result.verdict      = u8sc_pkg::VERDICT_INVALID;
                o_result.error_offset = w_start_wide[u8sc_pkg::ERR_OFFSET_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= 2'd0;
            r_seq_len  <= 3'd0;
            r_start    <= '0;
            r_error    <= 1'b0;
        end else if (i_step) begin
            r_expected <= n_expected;
            r_seq_len  <= n_seq_len;
            r_start    <= n_start;
            r_error    <= n_error;
        end
    end

    // An open sequence always knows a length longer than what it still owes
    a_len_covers_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_expected != 2'd0) |-> ({1'b0, r_expected} < r_seq_len))
        else $error("sequence length does not cover bytes still expected");

    // With no sequence open and no error, no length is held
    a_idle_len_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_error && (r_expected == 2'd0)) |-> (r_seq_len == 3'd0))
        else $error("stale sequence length");

    // An error sticks until the end of the stream
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error && !(i_step && (i_op == u8sc_pkg::OP_END))) |=> r_error)
        else $error("error flag dropped before end of stream");

    // End of stream returns all state to zero
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_op == u8sc_pkg::OP_END)) |=>
        (!r_error && (r_expected == 2'd0) && (r_seq_len == 3'd0) && (r_start == '0)))
        else $error("state not cleared at end of stream");

    // Data bytes never move the sequence start backward
    a_start_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_op == u8sc_pkg::OP_DATA)) |=> (r_start >= $past(r_start)))
        else $error("sequence start moved backward");

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for utf8_structure_checker_top.
// Drives byte and end-of-stream requests and checks each result against a built-in tracker.
// Depends on u8sc_pkg and the RTL under src/.
`timescale 1ns / 100ps

module testbench;

    // Highest offset the tracker can hold before it saturates (default offset width).
    localparam logic [63:0] OFFSET_CEIL = (64'd1 << u8sc_pkg::OFFSET_BITS_DEF) - 64'd1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_op = u8sc_pkg::OP_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_verdict;
    logic [u8sc_pkg::ERR_OFFSET_W-1:0] o_error_offset;

    utf8_structure_checker_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_verdict      (o_verdict),
        .o_error_offset (o_error_offset)
    );

    // 10 ns clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stream tracker: mirrors the checker's state so every accepted
    // request yields the verdict the block must return for it.
    // ------------------------------------------------------------------
    logic [1:0]  owed_cont   = '0;  // continuation bytes still due
    logic [63:0] seq_start   = '0;  // offset of the open sequence's first byte
    logic [2:0]  seq_len     = '0;  // length of the open sequence
    logic        err_latched = 1'b0;

    u8sc_pkg::t_result verdicts_due[$];   // results owed by the block, oldest first

    int send_idle_pct  = 0;         // chance per cycle that the sender holds off
    int recv_stall_pct = 0;         // chance per cycle that the receiver stalls
    int request_count  = 0;
    int stream_count   = 0;
    int result_count   = 0;
    int error_count    = 0;

    // Advance the sequence start, saturating at the top of the offset range.
    function automatic logic [63:0] bump_offset(logic [63:0] base, logic [63:0] n);
        return (OFFSET_CEIL - base < n) ? OFFSET_CEIL : base + n;
    endfunction

    function automatic u8sc_pkg::t_result track_stream_byte(logic op, logic [7:0] b);
        u8sc_pkg::t_result r;
        if (op == u8sc_pkg::OP_END) begin
            // An open sequence at end of stream counts as an error at its start.
            if (err_latched || owed_cont != 2'd0) begin
                r.verdict      = u8sc_pkg::VERDICT_INVALID;
                r.error_offset = seq_start[u8sc_pkg::ERR_OFFSET_W-1:0];
            end else begin
                r.verdict      = u8sc_pkg::VERDICT_VALID;
                r.error_offset = '0;
            end
            owed_cont   = '0;
            seq_start   = '0;
            seq_len     = '0;
            err_latched = 1'b0;
            return r;
        end
        // Once an error is latched, further data is ignored.
        if (!err_latched) begin
            if (owed_cont == 2'd0) begin
                casez (b)
                    8'b0???????: seq_start = bump_offset(seq_start, 64'd1);
                    8'b110?????: begin owed_cont = 2'd1; seq_len = 3'd2; end
                    8'b1110????: begin owed_cont = 2'd2; seq_len = 3'd3; end
                    8'b11110???: begin owed_cont = 2'd3; seq_len = 3'd4; end
                    default:     err_latched = 1'b1;  // stray continuation or F8..FF
                endcase
            end else if ((b & ~u8sc_pkg::PAYLOAD_MASK) == u8sc_pkg::CONT_MARK) begin
                owed_cont = owed_cont - 2'd1;
                if (owed_cont == 2'd0) begin
                    seq_start = bump_offset(seq_start, 64'(seq_len));
                    seq_len   = '0;
                end
            end else begin
                // Non-continuation inside a sequence: error at the sequence start.
                err_latched = 1'b1;
            end
        end
        if (err_latched) begin
            r.verdict      = u8sc_pkg::VERDICT_INVALID;
            r.error_offset = seq_start[u8sc_pkg::ERR_OFFSET_W-1:0];
        end else begin
            r.verdict      = u8sc_pkg::VERDICT_NONE;
            r.error_offset = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (error_count < 40)
            $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls at the falling edge, checks at the rising edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        u8sc_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            result_count++;
            if (verdicts_due.size() == 0) begin
                report_mismatch("result with nothing outstanding", o_verdict, 0);
            end else begin
                want = verdicts_due.pop_front();
                if (o_verdict !== want.verdict)
                    report_mismatch("verdict", o_verdict, want.verdict);
                if (o_error_offset !== want.error_offset)
                    report_mismatch("error_offset", o_error_offset, want.error_offset);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side. Each call starts and ends just after a falling edge.
    // ------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [7:0] b);
        // Idle for a random number of cycles, one drive per edge.
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        // Hold the request until the block takes it.
        do @(posedge i_clk); while (!o_ready);
        verdicts_due.push_back(track_stream_byte(op, b));
        request_count++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (verdicts_due.size() != 0);
    endtask

    // One character: a lead of the given class plus n_sent continuation bytes.
    task automatic send_char(input int n_cont, input int n_sent);
        logic [7:0] lead;
        case (n_cont)
            0:       lead = 8'($urandom_range(8'h00, 8'h7F));
            1:       lead = 8'($urandom_range(8'hC0, 8'hDF));
            2:       lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF7));
        endcase
        send_request(u8sc_pkg::OP_DATA, lead);
        for (int k = 0; k < n_sent; k++)
            send_request(u8sc_pkg::OP_DATA, 8'($urandom_range(8'h80, 8'hBF)));
    endtask

    task automatic end_stream(input logic [7:0] b);
        send_request(u8sc_pkg::OP_END, b);
        stream_count++;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // End marker on an empty stream; the byte lane must be ignored.
    task automatic test_empty_stream();
        end_stream(8'hFF);
    endtask

    // ASCII extremes and each multi-byte length with extreme leads and continuations.
    task automatic test_well_formed();
        send_request(u8sc_pkg::OP_DATA, 8'h00);
        send_request(u8sc_pkg::OP_DATA, 8'h7F);
        send_request(u8sc_pkg::OP_DATA, 8'hC0);
        send_request(u8sc_pkg::OP_DATA, 8'hBF);
        send_request(u8sc_pkg::OP_DATA, 8'hDF);
        send_request(u8sc_pkg::OP_DATA, 8'h80);
        send_request(u8sc_pkg::OP_DATA, 8'hE0);
        send_request(u8sc_pkg::OP_DATA, 8'h80);
        send_request(u8sc_pkg::OP_DATA, 8'hBF);
        send_request(u8sc_pkg::OP_DATA, 8'hF7);
        send_request(u8sc_pkg::OP_DATA, 8'hBF);
        send_request(u8sc_pkg::OP_DATA, 8'h80);
        send_request(u8sc_pkg::OP_DATA, 8'hBF);
        end_stream(8'h00);
    endtask

    // Stray continuation, then data after the error; then an illegal lead.
    task automatic test_stray_and_bad_lead();
        send_request(u8sc_pkg::OP_DATA, 8'h41);
        send_request(u8sc_pkg::OP_DATA, 8'h80);
        send_request(u8sc_pkg::OP_DATA, 8'hFF);
        end_stream(8'h5A);
        send_request(u8sc_pkg::OP_DATA, 8'hF8);
        end_stream(8'hA5);
    endtask

    // A lead where a continuation is due breaks the open sequence.
    task automatic test_broken_sequence();
        send_request(u8sc_pkg::OP_DATA, 8'hE3);
        send_request(u8sc_pkg::OP_DATA, 8'h41);
        end_stream(8'h80);
    endtask

    // Stream ending in the middle of a four-byte sequence.
    task automatic test_truncated_end();
        send_request(u8sc_pkg::OP_DATA, 8'h41);
        send_request(u8sc_pkg::OP_DATA, 8'hF0);
        send_request(u8sc_pkg::OP_DATA, 8'h80);
        end_stream(8'h7F);
    endtask

    // ------------------------------------------------------------------
    // Random streams: mostly well-formed text, with a share of corrupted
    // and pure-noise streams. Offset saturation needs 2^32 bytes and is
    // out of reach here; the tracker still models it.
    // ------------------------------------------------------------------
    task automatic send_random_stream();
        int n_chars;
        int flavor;
        int bad_at;
        int kind;
        n_chars = $urandom_range(0, 12);
        flavor  = $urandom_range(0, 9);
        bad_at  = $urandom_range(0, n_chars);
        for (int c = 0; c < n_chars; c++) begin
            kind = $urandom_range(0, 3);
            if (flavor == 9)
                send_request(u8sc_pkg::OP_DATA, 8'($urandom_range(0, 255)));
            else if (c != bad_at || flavor < 6)
                send_char(kind, kind);
            else if (flavor == 6)
                send_request(u8sc_pkg::OP_DATA, 8'($urandom_range(8'h80, 8'hBF)));
            else if (flavor == 7)
                send_request(u8sc_pkg::OP_DATA, 8'($urandom_range(8'hF8, 8'hFF)));
            else begin
                // Cut a multi-byte character short.
                kind = $urandom_range(1, 3);
                send_char(kind, $urandom_range(0, kind - 1));
            end
        end
        end_stream(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_streams(input int idle_pct, input int stall_pct,
                                       input int quota);
        int stop_at;
        int n;
        stop_at        = request_count + quota;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        n = 0;
        while (request_count < stop_at) begin
            send_random_stream();
            n++;
            if (n % 30 == 0)
                hold_until_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_stream();
        test_well_formed();
        test_stray_and_bad_lead();
        test_broken_sequence();
        test_truncated_end();

        test_random_streams(0, 0, 490);
        test_random_streams(55, 0, 490);
        test_random_streams(0, 55, 490);
        test_random_streams(22, 22, 490);

        hold_until_drained();
        // Allow for the two-stage pipeline; nothing more may arrive.
        repeat (8) @(posedge i_clk);

        $display("Covered %0d requests in %0d streams, %0d results checked,",
                 request_count, stream_count, result_count);
        $display("under free-running, sender-idle, receiver-stall and mixed traffic.");
        if (error_count == 0 && verdicts_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/u8sc_pkg.sv
src/u8sc_classify.sv
src/u8sc_core.sv
src/utf8_structure_checker_top.sv
bench/testbench.sv
